// File: hdl/top_k_cpu_usage_select_unit_defines.svh
// Assertion macros for the top-k usage selection unit.
`ifndef TOP_K_CPU_USAGE_SELECT_UNIT_DEFINES_SVH
`define TOP_K_CPU_USAGE_SELECT_UNIT_DEFINES_SVH

// Checks a condition in the same cycle as its trigger.
`define TKCUS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks a condition in the cycle after its trigger.
`define TKCUS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/tkcus_pkg.sv
package tkcus_pkg;

   localparam int KEEP_W = 6;
   localparam int PID_W  = 22;
   localparam int TIME_W = 64;
   localparam int RANK_W = 5;

   localparam logic [TIME_W-1:0] ELAPSED_RST = 64'd10000000;
   localparam logic [KEEP_W-1:0] KEEP_RST    = 6'd16;

   // Request kinds.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_FRAME  = 1'b1;

   // Register selects, taken from address bit 3.
   localparam logic REG_ELAPSED = 1'b0;
   localparam logic REG_KEEP    = 1'b1;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] tenths;
   } slot_type;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DIFF   = 9'b000000010,
      ST_MUL    = 9'b000000100,
      ST_COMB   = 9'b000001000,
      ST_PREP   = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_LOAD   = 9'b001000000,
      ST_INSERT = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

endpackage

// File: hdl/top_k_cpu_usage_select_unit.sv
// Sample transaction: busy through the setup states, the bit-per-cycle divider and a pass over
// slot rows 0 to stop, where stop is the last list row touched (at most TOP_DEPTH - 1). A zero
// interval or a saturated product skips the divider; a keep count of zero skips the list pass.
// Frame-end transaction: n results on consecutive cycles, the first once row 0 has been read;
// an empty list gives one result in the cycle after acceptance. Results cannot be stalled.
// Synchronous reset restores the registers and empties the list.
`include "top_k_cpu_usage_select_unit_defines.svh"

module top_k_cpu_usage_select_unit import tkcus_pkg::*; #(
   parameter int TOP_DEPTH     = 32,
   parameter int PERCENT_SCALE = 1000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [PID_W-1:0]  req_proc_id,
   input  logic [TIME_W-1:0] req_user_now,
   input  logic [TIME_W-1:0] req_system_now,
   input  logic [TIME_W-1:0] req_user_before,
   input  logic [TIME_W-1:0] req_system_before,
   input  logic              req_has_before,
   output logic              rsp_strobe,
   output logic [RANK_W-1:0] rsp_rank,
   output logic [PID_W-1:0]  rsp_out_proc_id,
   output logic [TIME_W-1:0] rsp_usage_tenths,
   output logic              rsp_empty_res,
   output logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [TIME_W-1:0] pwdata,
   output logic [TIME_W-1:0] prdata,
   output logic              pready
);

   localparam int IDX_W    = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
   localparam int CNT_W    = $clog2(TOP_DEPTH + 1);
   localparam int CMP_W    = (CNT_W > KEEP_W + 1) ? CNT_W : KEEP_W + 1;
   localparam int SCALE_W  = $clog2(PERCENT_SCALE + 1);
   localparam int HALF_W   = TIME_W / 2;
   localparam int PROD_W   = HALF_W + SCALE_W;
   localparam int SCALED_W = TIME_W + SCALE_W;
   localparam int STEP_W   = $clog2(TIME_W);

   localparam logic [SCALE_W-1:0] SCALE_C   = SCALE_W'(PERCENT_SCALE);
   localparam logic [CMP_W-1:0]   DEPTH_C   = CMP_W'(TOP_DEPTH);
   localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(TIME_W - 1);

   // Control state.
   state_type         state_ff, state_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // Datapath.
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] was_ff, was_in;
   logic              has_ff, has_in;
   logic [TIME_W-1:0] diff_ff, diff_in;
   logic [PROD_W-1:0] prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0] prod_hi_ff, prod_hi_in;
   logic [TIME_W-1:0] scaled_ff, scaled_in;
   logic              sat_ff, sat_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CMP_W-1:0]  idx_ff, idx_in;
   logic [CMP_W-1:0]  stop_ff, stop_in;
   logic              placed_ff, placed_in;
   slot_type          carry_ff, carry_in;
   logic [CMP_W-1:0]  emit_n_ff, emit_n_in;
   logic [RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;

   // Slot memory and its ports.
   slot_type          slot_mem_ff [TOP_DEPTH];
   slot_type          rd_data_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   slot_type          wr_data;

   // Combinational helpers.
   logic              accept;
   logic              csr_write;
   logic [TIME_W:0]   sum_now;
   logic [TIME_W:0]   sum_was;
   logic [SCALED_W-1:0] scaled_full;
   logic [TIME_W:0]   round_sum;
   logic [TIME_W:0]   rem_shift;
   logic [TIME_W+1:0] trial;
   logic [CMP_W-1:0]  keep_c;
   logic [CMP_W-1:0]  rows;
   logic [CMP_W-1:0]  cnt_c;
   logic              have;
   logic              place;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[3] == REG_KEEP) ? TIME_W'(keep_ff) : elapsed_ff;

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_rank         = rsp_rank_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_empty_res    = rsp_empty_ff;
   assign rsp_out_proc_id  = rsp_empty_ff ? '0 : rd_data_ff.pid;
   assign rsp_usage_tenths = rsp_empty_ff ? '0 : rd_data_ff.tenths;

   assign sum_now     = {1'b0, req_user_now} + {1'b0, req_system_now};
   assign sum_was     = {1'b0, req_user_before} + {1'b0, req_system_before};
   assign scaled_full = {prod_hi_ff, {HALF_W{1'b0}}} + SCALED_W'(prod_lo_ff);
   assign round_sum   = {1'b0, scaled_ff} + {1'b0, (elapsed_ff >> 1)};
   assign rem_shift   = {rem_ff, q_ff[TIME_W-1]};
   assign trial       = {1'b0, rem_shift} - {2'b00, elapsed_ff};

   // Keep counts above the memory depth act as the full depth.
   assign keep_c = CMP_W'(keep_ff);
   assign rows   = (keep_c > DEPTH_C) ? DEPTH_C : keep_c;
   assign cnt_c  = CMP_W'(count_ff);
   assign have   = (idx_ff < cnt_c);
   // Ties keep the held entry ahead, so the new one is placed only ahead of a strictly smaller value.
   assign place  = !placed_ff && (!have || (rd_data_ff.tenths < q_ff));

   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      keep_in       = keep_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      pid_in        = pid_ff;
      now_in        = now_ff;
      was_in        = was_ff;
      has_in        = has_ff;
      diff_in       = diff_ff;
      prod_lo_in    = prod_lo_ff;
      prod_hi_in    = prod_hi_ff;
      scaled_in     = scaled_ff;
      sat_in        = sat_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      stop_in       = stop_ff;
      placed_in     = placed_ff;
      carry_in      = carry_ff;
      emit_n_in     = emit_n_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = carry_ff;

      if (csr_write) begin
         if (paddr[3] == REG_ELAPSED) begin
            elapsed_in = pwdata;
         end else begin
            keep_in = pwdata[KEEP_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_SAMPLE) begin
                  pid_in   = req_proc_id;
                  now_in   = sum_now[TIME_W] ? '1 : sum_now[TIME_W-1:0];
                  was_in   = sum_was[TIME_W] ? '1 : sum_was[TIME_W-1:0];
                  has_in   = req_has_before;
                  state_in = ST_DIFF;
               end else begin
                  count_in = '0;
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_empty_in  = 1'b1;
                     rsp_last_in   = 1'b1;
                     rsp_rank_in   = '0;
                  end else begin
                     emit_n_in = cnt_c;
                     idx_in    = '0;
                     state_in  = ST_EMIT;
                  end
               end
            end
         end
         ST_DIFF: begin
            diff_in  = (has_ff && (now_ff >= was_ff)) ? now_ff - was_ff : '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_lo_in = PROD_W'(diff_ff[HALF_W-1:0]) * PROD_W'(SCALE_C);
            prod_hi_in = PROD_W'(diff_ff[TIME_W-1:HALF_W]) * PROD_W'(SCALE_C);
            state_in   = ST_COMB;
         end
         ST_COMB: begin
            scaled_in = scaled_full[TIME_W-1:0];
            sat_in    = |scaled_full[SCALED_W-1:TIME_W];
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            if (elapsed_ff == '0) begin
               q_in     = '0;
               state_in = ST_LOAD;
            end else if (sat_ff) begin
               q_in     = '1;
               state_in = ST_LOAD;
            end else begin
               // Rounding is dropped when adding half the interval would overflow.
               q_in     = round_sum[TIME_W] ? scaled_ff : round_sum[TIME_W-1:0];
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!trial[TIME_W+1]) begin
               rem_in = trial[TIME_W-1:0];
               q_in   = {q_ff[TIME_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[TIME_W-1:0];
               q_in   = {q_ff[TIME_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (rows == '0) begin
               state_in = ST_IDLE;
            end else begin
               stop_in   = (cnt_c < rows) ? cnt_c : rows - CMP_W'(1);
               idx_in    = '0;
               placed_in = 1'b0;
               carry_in  = '{pid: pid_ff, tenths: q_ff};
               rd_en     = 1'b1;
               rd_addr   = '0;
               state_in  = ST_INSERT;
            end
         end
         ST_INSERT: begin
            // The carry holds the new entry until it is placed, then the entry pushed down.
            if (place || placed_ff) begin
               wr_en    = 1'b1;
               carry_in = rd_data_ff;
            end
            placed_in = placed_ff || place;
            if (idx_ff == stop_ff) begin
               if ((placed_ff || place) && (cnt_c < rows)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end else begin
               idx_in  = idx_ff + CMP_W'(1);
               rd_en   = 1'b1;
               rd_addr = idx_in[IDX_W-1:0];
            end
         end
         ST_EMIT: begin
            rd_en         = 1'b1;
            rd_addr       = idx_ff[IDX_W-1:0];
            rsp_strobe_in = 1'b1;
            rsp_rank_in   = idx_ff[RANK_W-1:0];
            rsp_empty_in  = 1'b0;
            rsp_last_in   = (idx_ff + CMP_W'(1) == emit_n_ff);
            idx_in        = idx_ff + CMP_W'(1);
            if (idx_ff + CMP_W'(1) == emit_n_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         elapsed_ff    <= ELAPSED_RST;
         keep_ff       <= KEEP_RST;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         elapsed_ff    <= elapsed_in;
         keep_ff       <= keep_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff       <= pid_in;
      now_ff       <= now_in;
      was_ff       <= was_in;
      has_ff       <= has_in;
      diff_ff      <= diff_in;
      prod_lo_ff   <= prod_lo_in;
      prod_hi_ff   <= prod_hi_in;
      scaled_ff    <= scaled_in;
      sat_ff       <= sat_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      stop_ff      <= stop_in;
      placed_ff    <= placed_in;
      carry_ff     <= carry_in;
      emit_n_ff    <= emit_n_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // The insert pass writes row i while reading row i + 1, so no access ever
   // meets a write to the same row in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   `TKCUS_ASSERT_NEXT(a_frame_clears, clock, reset, accept && req_type == REQ_FRAME, count_ff == '0, "entry count not cleared by frame end")
   `TKCUS_ASSERT_NOW(a_insert_range, clock, reset, state_ff == ST_INSERT, idx_ff <= stop_ff && stop_ff < DEPTH_C, "insert pass outside the list")
   `TKCUS_ASSERT_NEXT(a_emit_strobe, clock, reset, state_ff == ST_EMIT, rsp_strobe && !rsp_empty_res, "list read without a result")
   `TKCUS_ASSERT_NOW(a_empty_final, clock, reset, rsp_strobe && rsp_empty_res, rsp_last && rsp_rank == '0 && count_ff == '0, "malformed empty-list result")

endmodule

// File: dv/tb_top_k_cpu_usage_select_unit.sv
`timescale 1ns / 1ps

module tb_top_k_cpu_usage_select_unit;
   import tkcus_pkg::*;

   localparam int TOP_DEPTH     = 32;
   localparam int PERCENT_SCALE = 1000;
   // Long enough for the worst sample transaction and for a full frame to drain.
   localparam int SETTLE_CYCLES = 120;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 125;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic              kind;
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] user_now;
      logic [TIME_W-1:0] system_now;
      logic [TIME_W-1:0] user_before;
      logic [TIME_W-1:0] system_before;
      logic              has_before;
   } sample_req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] tenths;
      logic              empty;
      logic              last;
   } usage_rec_type;

   typedef struct packed {
      row_kind_type      kind;
      sample_req_type    req;
      logic              reg_sel;
      logic [TIME_W-1:0] wdata;
      logic              typed;
      usage_rec_type     want;
   } stim_row_type;

   localparam usage_rec_type EMPTY_LIST = '{'0, '0, '0, 1'b1, 1'b1};

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_type;
   logic [PID_W-1:0]  req_proc_id;
   logic [TIME_W-1:0] req_user_now;
   logic [TIME_W-1:0] req_system_now;
   logic [TIME_W-1:0] req_user_before;
   logic [TIME_W-1:0] req_system_before;
   logic              req_has_before;
   logic              rsp_strobe;
   logic [RANK_W-1:0] rsp_rank;
   logic [PID_W-1:0]  rsp_out_proc_id;
   logic [TIME_W-1:0] rsp_usage_tenths;
   logic              rsp_empty_res;
   logic              rsp_last;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [3:0]        paddr;
   logic [TIME_W-1:0] pwdata;
   logic [TIME_W-1:0] prdata;
   logic              pready;

   top_k_cpu_usage_select_unit #(
      .TOP_DEPTH     (TOP_DEPTH),
      .PERCENT_SCALE (PERCENT_SCALE)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_proc_id       (req_proc_id),
      .req_user_now      (req_user_now),
      .req_system_now    (req_system_now),
      .req_user_before   (req_user_before),
      .req_system_before (req_system_before),
      .req_has_before    (req_has_before),
      .rsp_strobe        (rsp_strobe),
      .rsp_rank          (rsp_rank),
      .rsp_out_proc_id   (rsp_out_proc_id),
      .rsp_usage_tenths  (rsp_usage_tenths),
      .rsp_empty_res     (rsp_empty_res),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Shadow copy of the ranking list and the registers.
   logic [PID_W-1:0]  top_pid [TOP_DEPTH];
   logic [TIME_W-1:0] top_tenths [TOP_DEPTH];
   int unsigned       top_count;
   logic [TIME_W-1:0] cfg_elapsed;
   logic [KEEP_W-1:0] cfg_keep;

   usage_rec_type ranked_due[$];
   int            mismatches;
   int            stall_cycles;
   int            burst_left;

   function automatic logic [TIME_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a, b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] tenths_of(input logic [TIME_W-1:0] part, whole);
      logic [TIME_W-1:0] scaled;
      logic [TIME_W-1:0] half;
      if (whole == '0) return '0;
      if (part > TIME_MAX / TIME_W'(PERCENT_SCALE)) return TIME_MAX;
      scaled = part * TIME_W'(PERCENT_SCALE);
      half = whole >> 1;
      // Rounding is dropped when adding half the interval would wrap.
      if (scaled <= TIME_MAX - half) return (scaled + half) / whole;
      return scaled / whole;
   endfunction

   task automatic insert_usage(input logic [PID_W-1:0] pid, input logic [TIME_W-1:0] tenths);
      int unsigned rows;
      int unsigned at;
      int unsigned stop;
      rows = (cfg_keep > TOP_DEPTH) ? TOP_DEPTH : cfg_keep;
      at = 0;
      while (at < top_count && at < TOP_DEPTH && top_tenths[at] >= tenths) at++;
      if (at >= rows) return;
      // With the keep count lowered mid-frame the tail row is overwritten, not appended.
      stop = (top_count < rows) ? top_count : rows - 1;
      for (int unsigned j = stop; j > at; j--) begin
         top_pid[j]    = top_pid[j-1];
         top_tenths[j] = top_tenths[j-1];
      end
      top_pid[at]    = pid;
      top_tenths[at] = tenths;
      if (top_count < rows) top_count++;
   endtask

   task automatic rank_transaction(input sample_req_type r, input logic typed,
                                   input usage_rec_type want);
      logic [TIME_W-1:0] used;
      int unsigned       n;
      usage_rec_type     rec;
      if (r.kind == REQ_SAMPLE) begin
         used = '0;
         if (r.has_before) begin
            used = sat_sum(r.user_now, r.system_now);
            rec.tenths = sat_sum(r.user_before, r.system_before);
            used = (used >= rec.tenths) ? used - rec.tenths : '0;
         end
         insert_usage(r.pid, tenths_of(used, cfg_elapsed));
         return;
      end
      n = (top_count > TOP_DEPTH) ? TOP_DEPTH : top_count;
      top_count = 0;
      if (typed) begin
         ranked_due.push_back(want);
      end else if (n == 0) begin
         ranked_due.push_back(EMPTY_LIST);
      end else begin
         for (int unsigned i = 0; i < n; i++) begin
            rec.rank   = RANK_W'(i);
            rec.pid    = top_pid[i];
            rec.tenths = top_tenths[i];
            rec.empty  = 1'b0;
            rec.last   = (i + 1 == n);
            ranked_due.push_back(rec);
         end
      end
   endtask

   // Presents one transaction and returns at the edge that accepts it, start still high.
   task automatic issue(input sample_req_type r, input logic typed, input usage_rec_type want);
      req_type          <= r.kind;
      req_proc_id       <= r.pid;
      req_user_now      <= r.user_now;
      req_system_now    <= r.system_now;
      req_user_before   <= r.user_before;
      req_system_before <= r.system_before;
      req_has_before    <= r.has_before;
      if (start !== 1'b1) start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      rank_transaction(r, typed, want);
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(1, 6);
      end
      burst_left--;
   endtask

   task automatic settle();
      start <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0 || ranked_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [TIME_W-1:0] value);
      settle();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_sel, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (reg_sel == REG_ELAPSED) cfg_elapsed = value;
      else cfg_keep = value[KEEP_W-1:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic stim_row_type proc_row(input logic [PID_W-1:0] pid,
                                             input logic [TIME_W-1:0] un, sn, ub, sb,
                                             input logic hb);
      stim_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.req  = '{REQ_SAMPLE, pid, un, sn, ub, sb, hb};
      return r;
   endfunction

   function automatic stim_row_type frame_row(input logic typed, input usage_rec_type want);
      stim_row_type r;
      r = '0;
      r.kind     = ROW_ITEM;
      r.req.kind = REQ_FRAME;
      r.typed    = typed;
      r.want     = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic reg_sel,
                                            input logic [TIME_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.kind    = ROW_CSR;
      r.reg_sel = reg_sel;
      r.wdata   = value;
      return r;
   endfunction

   function automatic sample_req_type draw_sample();
      sample_req_type    r;
      logic [TIME_W-1:0] tie_pool [4];
      logic [TIME_W-1:0] du;
      logic [TIME_W-1:0] ds;
      int                mode;
      tie_pool = '{64'd0, 64'd1000, 64'd250000, 64'd5000000};
      r.kind        = REQ_SAMPLE;
      r.pid         = PID_W'($urandom);
      r.has_before  = ($urandom_range(0, 7) != 0);
      r.user_before   = rand64() >> $urandom_range(0, 63);
      r.system_before = rand64() >> $urandom_range(0, 63);
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
         // Pooled deltas give equal usages, which exercises the tie ordering.
         du = tie_pool[$urandom_range(0, 3)];
         ds = tie_pool[$urandom_range(0, 3)];
      end else begin
         du = rand64() >> $urandom_range(mode < 8 ? 20 : 0, 63);
         ds = rand64() >> $urandom_range(mode < 8 ? 20 : 0, 63);
      end
      r.user_now   = r.user_before + du;
      r.system_now = r.system_before + ds;
      if (mode == 9) begin
         r.user_now   = rand64();
         r.system_now = rand64();
      end
      return r;
   endfunction

   always @(posedge clock) begin : rsp_check
      usage_rec_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (ranked_due.size() == 0) begin
            $error("result with no transaction pending: rank %0d pid %0d",
                   rsp_rank, rsp_out_proc_id);
            mismatches++;
         end else begin
            want = ranked_due.pop_front();
            if (rsp_rank !== want.rank) begin
               $error("rank: expected %0d, actual %0d", want.rank, rsp_rank);
               mismatches++;
            end
            if (rsp_out_proc_id !== want.pid) begin
               $error("out_proc_id: expected %0d, actual %0d", want.pid, rsp_out_proc_id);
               mismatches++;
            end
            if (rsp_usage_tenths !== want.tenths) begin
               $error("usage_tenths: expected %0d, actual %0d", want.tenths, rsp_usage_tenths);
               mismatches++;
            end
            if (rsp_empty_res !== want.empty) begin
               $error("empty_res: expected %0d, actual %0d", want.empty, rsp_empty_res);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1 ||
          (psel && penable && pwrite && pready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      stim_row_type   plan[$];
      sample_req_type r;
      int             sent;
      int             frame_len;
      logic [TIME_W-1:0] big;

      reset             <= 1'b1;
      start             <= 1'b0;
      req_type          <= REQ_SAMPLE;
      req_proc_id       <= '0;
      req_user_now      <= '0;
      req_system_now    <= '0;
      req_user_before   <= '0;
      req_system_before <= '0;
      req_has_before    <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      stall_cycles       = 0;
      mismatches         = 0;
      burst_left         = 0;
      top_count          = 0;
      cfg_elapsed        = ELAPSED_RST;
      cfg_keep           = KEEP_RST;
      foreach (top_pid[i]) begin
         top_pid[i]    = '0;
         top_tenths[i] = '0;
      end

      big = TIME_MAX / TIME_W'(PERCENT_SCALE);
      // Reset values: empty list, then a saturated sum that saturates the usage.
      plan.push_back(frame_row(1'b1, EMPTY_LIST));
      plan.push_back(proc_row(22'h3FFFFF, TIME_MAX, TIME_MAX, '0, '0, 1'b1));
      plan.push_back(frame_row(1'b1, '{'0, 22'h3FFFFF, TIME_MAX, 1'b0, 1'b1}));
      // No previous sample, a shrinking total, plain scaling and a round-up.
      plan.push_back(proc_row(22'd0, 64'd123, 64'd456, '0, '0, 1'b0));
      plan.push_back(proc_row(22'd5, 64'd100, 64'd0, 64'd200, 64'd0, 1'b1));
      plan.push_back(proc_row(22'd7, 64'd5000000, 64'd0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'd9, 64'd3000, 64'd2000, '0, '0, 1'b1));
      plan.push_back(frame_row(1'b0, '0));
      // Smallest interval and a single kept row; the product overflows.
      plan.push_back(csr_row(REG_ELAPSED, 64'd1));
      plan.push_back(csr_row(REG_KEEP, 64'd1));
      plan.push_back(proc_row(22'd1, 64'd1000, '0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'd2, big + 64'd1, '0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'd3, 64'd2000, '0, '0, '0, 1'b1));
      plan.push_back(frame_row(1'b1, '{'0, 22'd2, TIME_MAX, 1'b0, 1'b1}));
      // Largest interval, where the rounding add would wrap; keep count above the depth.
      plan.push_back(csr_row(REG_ELAPSED, TIME_MAX));
      plan.push_back(csr_row(REG_KEEP, 64'd63));
      plan.push_back(proc_row(22'h2AAAAA, big, '0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'h155555, TIME_MAX, '0, '0, 64'd1, 1'b1));
      plan.push_back(frame_row(1'b0, '0));
      // Zero interval gives zero usage.
      plan.push_back(csr_row(REG_ELAPSED, 64'd0));
      plan.push_back(csr_row(REG_KEEP, 64'd32));
      plan.push_back(proc_row(22'd11, 64'd77777777, '0, '0, '0, 1'b1));
      plan.push_back(frame_row(1'b1, '{'0, 22'd11, '0, 1'b0, 1'b1}));
      // Keep count lowered while the list already holds more entries.
      plan.push_back(csr_row(REG_ELAPSED, 64'd1000));
      plan.push_back(csr_row(REG_KEEP, 64'd4));
      plan.push_back(proc_row(22'd20, 64'd1000, '0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'd21, 64'd4000, '0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'd22, 64'd3000, '0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'd23, 64'd2000, '0, '0, '0, 1'b1));
      plan.push_back(csr_row(REG_KEEP, 64'd2));
      plan.push_back(proc_row(22'd24, 64'd9000, '0, '0, '0, 1'b1));
      plan.push_back(proc_row(22'd25, 64'd1, '0, '0, '0, 1'b1));
      plan.push_back(frame_row(1'b0, '0));
      // Keep count zero holds nothing.
      plan.push_back(csr_row(REG_KEEP, 64'd0));
      plan.push_back(proc_row(22'd26, 64'd5000, '0, '0, '0, 1'b1));
      plan.push_back(frame_row(1'b1, EMPTY_LIST));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            csr_write(plan[i].reg_sel, plan[i].wdata);
         end else begin
            pace();
            issue(plan[i].req, plan[i].typed, plan[i].want);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
               0: big = 64'd0;
               1: big = 64'd1;
               2: big = TIME_MAX;
               3: big = ELAPSED_RST;
               default: big = rand64() >> $urandom_range(0, 63);
            endcase
            csr_write(REG_ELAPSED, big);
         end
         if ($urandom_range(0, 1) == 0) begin
            big = rand64();
            big[KEEP_W-1:0] = ($urandom_range(0, 4) == 0) ? KEEP_W'($urandom_range(0, 63))
                                                          : KEEP_W'($urandom_range(1, 32));
            csr_write(REG_KEEP, big);
         end
         frame_len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40)
                                                 : $urandom_range(0, 10);
         if (frame_len > RANDOM_ITEMS - sent - 1) frame_len = RANDOM_ITEMS - sent - 1;
         repeat (frame_len) begin
            if ($urandom_range(0, 29) == 0) csr_write(REG_KEEP, 64'($urandom_range(0, 63)));
            pace();
            issue(draw_sample(), 1'b0, '0);
            sent++;
         end
         // The frame-end transaction carries random fields, which are ignored.
         r = draw_sample();
         r.kind = REQ_FRAME;
         pace();
         issue(r, 1'b0, '0);
         sent++;
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ranked_due.size() != 0) begin
         $error("%0d expected results never arrived", ranked_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
